>>> src/sovg_pkg.sv
package sovg_pkg;

   typedef logic signed [63:0] word_type;

   typedef enum logic [1:0] {
      REG_COEFF_FIRST,
      REG_COEFF_SECOND,
      REG_EXPO_FIRST,
      REG_EXPO_SECOND
   } reg_index_type;

   localparam word_type WMAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam word_type KYLM_Q32  = 64'sd2346229909;
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [31:0] LN2_Q32   = 32'd2977044472;

   localparam int SERIES_TERMS = 12;
   localparam int MUL_LAT      = 4;
   localparam int EXP_LAT      = 3 + 3 * SERIES_TERMS + 1;
   localparam int ROOT_STEPS   = 32;
   localparam int DIV_STEPS    = 33;

   function automatic logic [63:0] mag64(input word_type v);
      mag64 = v[63] ? 64'(-v) : 64'(v);
   endfunction

   // saturating add, limited to +-WMAX
   function automatic word_type sat_add(input word_type a, input word_type b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(WMAX))
         sat_add = WMAX;
      else if (s < -65'(WMAX))
         sat_add = -WMAX;
      else
         sat_add = s[63:0];
   endfunction

   // Q32 working value to Q8.24 output, truncated toward zero and saturated
   function automatic logic [31:0] to_q24(input word_type w);
      logic [63:0] m;
      m = mag64(w) >> 8;
      if (w[63]) begin
         if (m > 64'h8000_0000)
            m = 64'h8000_0000;
         to_q24 = 32'(64'd0 - m);
      end else begin
         if (m > 64'h7FFF_FFFF)
            m = 64'h7FFF_FFFF;
         to_q24 = m[31:0];
      end
   endfunction

endpackage

>>> src/slater_orbital_value_gradient.sv
// throughput: one word per cycle while the rsp side does not stall the pipeline
// the datapath is a 98-stage pipeline with one output register
// the square root and the three unit-vector dividers resolve one bit per stage
// a stalled rsp side freezes the pipeline only once its last stage holds a word
// reset clears the valid bits and loads the configuration registers with their defaults
module slater_orbital_value_gradient (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // center_x, center_y, center_z, point_x, point_y, point_z
   input  logic [191:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // orbital_value, grad_x, grad_y, grad_z
   output logic [127:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import sovg_pkg::*;

   localparam int S_R2   = 4;
   localparam int S_R    = S_R2 + ROOT_STEPS;
   localparam int S_Q    = S_R + DIV_STEPS;
   localparam int S_U    = S_Q + 1;
   localparam int S_E    = S_R + EXP_LAT;
   localparam int S_CE   = S_E + MUL_LAT;
   localparam int S_F    = S_CE + 1;
   localparam int S_G    = S_CE + MUL_LAT + 1;
   localparam int S_KF   = S_F + MUL_LAT;
   localparam int S_KG   = S_G + MUL_LAT;
   localparam int S_V    = S_KF + MUL_LAT;
   localparam int S_R1   = S_KG + MUL_LAT;
   localparam int S_RAD  = S_R1 + MUL_LAT;
   localparam int S_LAST = S_RAD + 1;

   // configuration registers
   logic signed [31:0] coeff_first_ff, coeff_second_ff;
   logic [30:0]        expo_first_ff, expo_second_ff;
   reg_index_type      csr_index;
   logic               csr_write;

   assign csr_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_first_ff  <= '0;
         coeff_second_ff <= '0;
         expo_first_ff   <= 31'd65536;
         expo_second_ff  <= 31'd65536;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_COEFF_FIRST:  coeff_first_ff  <= csr_pwdata;
            REG_COEFF_SECOND: coeff_second_ff <= csr_pwdata;
            REG_EXPO_FIRST:   expo_first_ff   <= csr_pwdata[30:0];
            REG_EXPO_SECOND:  expo_second_ff  <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_COEFF_FIRST:  csr_prdata = coeff_first_ff;
         REG_COEFF_SECOND: csr_prdata = coeff_second_ff;
         REG_EXPO_FIRST:   csr_prdata = {1'b0, expo_first_ff};
         REG_EXPO_SECOND:  csr_prdata = {1'b0, expo_second_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // flow control
   logic vld_ff [1:S_LAST];
   logic ce;
   logic rsp_valid_ff;
   logic [127:0] rsp_data_ff;

   assign ce         = !(vld_ff[S_LAST] && rsp_valid_ff && !rsp_tready);
   assign req_tready = ce;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= S_LAST; s++)
            vld_ff[s] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ce) begin
            vld_ff[1] <= req_tvalid;
            for (int s = 2; s <= S_LAST; s++)
               vld_ff[s] <= vld_ff[s-1];
         end
         if (!rsp_valid_ff || rsp_tready)
            rsp_valid_ff <= vld_ff[S_LAST];
      end
   end

   // displacement, magnitudes, squares
   logic signed [31:0] d_ff   [3][1:S_KF];
   logic [30:0]        m_ff   [3][2:S_R];
   logic [61:0]        sq_ff  [3];
   logic signed [32:0] diff_c [3];
   logic signed [31:0] d_in   [3];
   word_type           p_ff   [S_R2:S_R1];

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         diff_c[l] = 33'($signed(req_tdata[96 + 32*l +: 32]))
                   - 33'($signed(req_tdata[32*l +: 32]));
         if (diff_c[l] > 33'sh0_7FFF_FFFF)
            d_in[l] = 32'sh7FFF_FFFF;
         else if (diff_c[l] < -33'sh0_7FFF_FFFF)
            d_in[l] = -32'sh7FFF_FFFF;
         else
            d_in[l] = diff_c[l][31:0];
      end
   end

   // square root state: remaining radicand, partial remainder, partial root
   logic [63:0] sv_ff    [S_R2:S_R];
   logic [33:0] srem_ff  [S_R2:S_R];
   logic [31:0] sroot_ff [S_R2:S_R];

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int l = 0; l < 3; l++) begin
            d_ff[l][1] <= d_in[l];
            for (int s = 2; s <= S_KF; s++)
               d_ff[l][s] <= d_ff[l][s-1];
            m_ff[l][2] <= d_ff[l][1][31] ? 31'(-d_ff[l][1]) : d_ff[l][1][30:0];
            for (int s = 3; s <= S_R; s++)
               m_ff[l][s] <= m_ff[l][s-1];
            sq_ff[l] <= 62'(m_ff[l][2]) * 62'(m_ff[l][2]);
         end
         sv_ff[S_R2]    <= 64'(sq_ff[0]) + 64'(sq_ff[1]) + 64'(sq_ff[2]);
         srem_ff[S_R2]  <= '0;
         sroot_ff[S_R2] <= '0;
         p_ff[S_R2]     <= $signed(64'(sq_ff[0])) - $signed(64'(sq_ff[1]));
         for (int s = S_R2 + 1; s <= S_R1; s++)
            p_ff[s] <= p_ff[s-1];
      end
   end

   for (genvar s = S_R2 + 1; s <= S_R; s++) begin : g_root
      logic [35:0] cur;
      logic [35:0] trial;
      always_comb begin
         cur   = {srem_ff[s-1], sv_ff[s-1][63:62]};
         trial = {2'b00, sroot_ff[s-1], 2'b01};
      end
      always_ff @(posedge clock) begin
         if (ce) begin
            sv_ff[s] <= sv_ff[s-1] << 2;
            if (cur >= trial) begin
               srem_ff[s]  <= 34'(cur - trial);
               sroot_ff[s] <= {sroot_ff[s-1][30:0], 1'b1};
            end else begin
               srem_ff[s]  <= cur[33:0];
               sroot_ff[s] <= {sroot_ff[s-1][30:0], 1'b0};
            end
         end
      end
   end

   // unit vector components: (|d| << 32) / r, one quotient bit per stage
   logic [31:0] dr_ff   [S_R+1:S_Q];
   logic [31:0] drem_ff [3][S_R+1:S_Q];
   logic [32:0] dq_ff   [3][S_R+1:S_Q];
   word_type    u_ff    [3][S_U:S_KG];

   always_ff @(posedge clock) begin
      if (ce) begin
         dr_ff[S_R+1] <= sroot_ff[S_R];
         for (int s = S_R + 2; s <= S_Q; s++)
            dr_ff[s] <= dr_ff[s-1];
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      logic first_bit;
      assign first_bit = 32'(m_ff[l][S_R]) >= sroot_ff[S_R];

      always_ff @(posedge clock) begin
         if (ce) begin
            drem_ff[l][S_R+1] <= first_bit ? 32'(m_ff[l][S_R]) - sroot_ff[S_R]
                                           : 32'(m_ff[l][S_R]);
            dq_ff[l][S_R+1]   <= {32'd0, first_bit};
            // point on the center: unit vector is zero
            if (dr_ff[S_Q] == '0)
               u_ff[l][S_U] <= '0;
            else if (d_ff[l][S_Q][31])
               u_ff[l][S_U] <= -word_type'({31'd0, dq_ff[l][S_Q]});
            else
               u_ff[l][S_U] <= word_type'({31'd0, dq_ff[l][S_Q]});
            for (int s = S_U + 1; s <= S_KG; s++)
               u_ff[l][s] <= u_ff[l][s-1];
         end
      end

      for (genvar s = S_R + 2; s <= S_Q; s++) begin : g_div
         logic [32:0] t;
         logic        hit;
         always_comb begin
            t   = {drem_ff[l][s-1], 1'b0};
            hit = t >= 33'(dr_ff[s-1]);
         end
         always_ff @(posedge clock) begin
            if (ce) begin
               drem_ff[l][s] <= hit ? 32'(t - 33'(dr_ff[s-1])) : t[31:0];
               dq_ff[l][s]   <= {dq_ff[l][s-1][31:0], hit};
            end
         end
      end
   end

   // radial exponentials
   logic [32:0] e1, e2;

   sovg_nexp u_exp_first (
      .clock (clock),
      .en    (ce),
      .r     (sroot_ff[S_R]),
      .expo  (expo_first_ff),
      .e     (e1)
   );

   sovg_nexp u_exp_second (
      .clock (clock),
      .en    (ce),
      .r     (sroot_ff[S_R]),
      .expo  (expo_second_ff),
      .e     (e2)
   );

   word_type c1e, c2e, g1, g2, kf, kg, val, fx, fy, rx1, ry1, rz1, rx, ry, rz;
   word_type f_ff, g_ff;

   sovg_wmul u_mul_c1e (.clock(clock), .en(ce),
      .a($signed({{16{coeff_first_ff[31]}}, coeff_first_ff, 16'd0})),
      .b(word_type'({31'd0, e1})), .y(c1e));
   sovg_wmul u_mul_c2e (.clock(clock), .en(ce),
      .a($signed({{16{coeff_second_ff[31]}}, coeff_second_ff, 16'd0})),
      .b(word_type'({31'd0, e2})), .y(c2e));
   sovg_wmul u_mul_g1 (.clock(clock), .en(ce), .a(c1e),
      .b(word_type'({17'd0, expo_first_ff, 16'd0})), .y(g1));
   sovg_wmul u_mul_g2 (.clock(clock), .en(ce), .a(c2e),
      .b(word_type'({17'd0, expo_second_ff, 16'd0})), .y(g2));

   always_ff @(posedge clock) begin
      if (ce) begin
         f_ff <= sat_add(c1e, c2e);
         g_ff <= -sat_add(g1, g2);
      end
   end

   sovg_wmul u_mul_kf (.clock(clock), .en(ce), .a(KYLM_Q32), .b(f_ff), .y(kf));
   sovg_wmul u_mul_kg (.clock(clock), .en(ce), .a(KYLM_Q32), .b(g_ff), .y(kg));

   sovg_wmul u_mul_val (.clock(clock), .en(ce), .a(kf), .b(p_ff[S_KF]), .y(val));
   sovg_wmul u_mul_fx (.clock(clock), .en(ce), .a(kf),
      .b($signed({{16{d_ff[0][S_KF][31]}}, d_ff[0][S_KF], 16'd0})), .y(fx));
   sovg_wmul u_mul_fy (.clock(clock), .en(ce), .a(kf),
      .b($signed({{16{d_ff[1][S_KF][31]}}, d_ff[1][S_KF], 16'd0})), .y(fy));

   sovg_wmul u_mul_rx1 (.clock(clock), .en(ce), .a(kg), .b(u_ff[0][S_KG]), .y(rx1));
   sovg_wmul u_mul_ry1 (.clock(clock), .en(ce), .a(kg), .b(u_ff[1][S_KG]), .y(ry1));
   sovg_wmul u_mul_rz1 (.clock(clock), .en(ce), .a(kg), .b(u_ff[2][S_KG]), .y(rz1));
   sovg_wmul u_mul_rx (.clock(clock), .en(ce), .a(rx1), .b(p_ff[S_R1]), .y(rx));
   sovg_wmul u_mul_ry (.clock(clock), .en(ce), .a(ry1), .b(p_ff[S_R1]), .y(ry));
   sovg_wmul u_mul_rz (.clock(clock), .en(ce), .a(rz1), .b(p_ff[S_R1]), .y(rz));

   // 2*f*x and -2*f*y wait for the radial terms
   word_type val_ff [S_V+1:S_RAD];
   word_type fx2_ff [S_V+1:S_RAD];
   word_type fy2_ff [S_V+1:S_RAD];
   word_type gx_ff, gy_ff, gz_ff, vo_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         val_ff[S_V+1] <= val;
         fx2_ff[S_V+1] <= sat_add(fx, fx);
         fy2_ff[S_V+1] <= -sat_add(fy, fy);
         for (int s = S_V + 2; s <= S_RAD; s++) begin
            val_ff[s] <= val_ff[s-1];
            fx2_ff[s] <= fx2_ff[s-1];
            fy2_ff[s] <= fy2_ff[s-1];
         end
         vo_ff <= val_ff[S_RAD];
         gx_ff <= sat_add(rx, fx2_ff[S_RAD]);
         gy_ff <= sat_add(ry, fy2_ff[S_RAD]);
         gz_ff <= rz;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_tready)
         rsp_data_ff <= {to_q24(gz_ff), to_q24(gy_ff), to_q24(gx_ff), to_q24(vo_ff)};
   end

endmodule

>>> src/sovg_wmul.sv
module sovg_wmul (
   input  logic              clock,
   input  logic              en,
   input  sovg_pkg::word_type a,
   input  sovg_pkg::word_type b,
   output sovg_pkg::word_type y
);
   import sovg_pkg::*;

   logic        neg_s1_ff, neg_s2_ff, neg_s3_ff;
   logic [63:0] ma_ff, mb_ff;
   logic [63:0] ll_ff, lh_ff, hl_ff, hh_ff;
   logic [95:0] sum_ff;
   word_type    y_ff;
   logic [127:0] full;
   word_type    mag_sat;

   always_comb begin
      full = {64'd0, ll_ff} + {32'd0, lh_ff, 32'd0} + {32'd0, hl_ff, 32'd0}
           + {hh_ff, 64'd0};
   end

   // product >> 32 saturates once it reaches 2^63
   always_comb begin
      mag_sat = (|sum_ff[95:63]) ? WMAX : word_type'(sum_ff[63:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_s1_ff <= a[63] ^ b[63];
         ma_ff     <= mag64(a);
         mb_ff     <= mag64(b);
         neg_s2_ff <= neg_s1_ff;
         ll_ff     <= 64'(ma_ff[31:0])  * 64'(mb_ff[31:0]);
         lh_ff     <= 64'(ma_ff[31:0])  * 64'(mb_ff[63:32]);
         hl_ff     <= 64'(ma_ff[63:32]) * 64'(mb_ff[31:0]);
         hh_ff     <= 64'(ma_ff[63:32]) * 64'(mb_ff[63:32]);
         neg_s3_ff <= neg_s2_ff;
         sum_ff    <= full[127:32];
         y_ff      <= neg_s3_ff ? -mag_sat : mag_sat;
      end
   end

   assign y = y_ff;

endmodule

>>> src/sovg_nexp.sv
module sovg_nexp (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] r,
   input  logic [30:0] expo,
   output logic [32:0] e
);
   import sovg_pkg::*;

   localparam int LAST = 3 * SERIES_TERMS + 3;

   logic [62:0]        a_ff;
   logic [29:0]        t_ff;
   logic               zero_ff [2:LAST];
   logic [5:0]         k_ff    [3:LAST];
   logic [31:0]        u_ff    [3:3*SERIES_TERMS];
   logic [31:0]        p_ff    [1:SERIES_TERMS];
   logic [31:0]        pb_ff   [1:SERIES_TERMS];
   logic [31:0]        qe_ff   [1:SERIES_TERMS];
   logic signed [34:0] acca_ff [1:SERIES_TERMS];
   logic signed [34:0] accb_ff [1:SERIES_TERMS];
   logic signed [34:0] acc_ff  [1:SERIES_TERMS];
   logic [32:0]        term_ff [1:SERIES_TERMS];
   logic [32:0]        term_in [1:SERIES_TERMS];
   logic signed [34:0] acc_in  [1:SERIES_TERMS];
   logic [32:0]        e_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff       <= 63'(expo) * 63'(r);
         // argument of 32 or more gives exactly zero
         zero_ff[2] <= |a_ff[62:37];
         t_ff       <= 30'((60'(a_ff[36:8]) * 60'(LOG2E_Q30)) >> 30);
         zero_ff[3] <= zero_ff[2];
         k_ff[3]    <= t_ff[29:24];
         u_ff[3]    <= 32'((56'(t_ff[23:0]) * 56'(LN2_Q32)) >> 24);
         for (int s = 4; s <= LAST; s++) begin
            zero_ff[s] <= zero_ff[s-1];
            k_ff[s]    <= k_ff[s-1];
         end
         for (int s = 4; s <= 3 * SERIES_TERMS; s++)
            u_ff[s] <= u_ff[s-1];
         e_ff <= zero_ff[LAST] ? 33'd0 : 33'(acc_ff[SERIES_TERMS][32:0] >> k_ff[LAST]);
      end
   end

   for (genvar j = 1; j <= SERIES_TERMS; j++) begin : g_term
      localparam logic [36:0] RECIP = 37'((64'd1 << 36) / j);
      logic [31:0] rem;
      logic [32:0] q;

      if (j == 1) begin : g_first
         assign term_in[j] = 33'h1_0000_0000;
         assign acc_in[j]  = 35'sh1_0000_0000;
      end else begin : g_next
         assign term_in[j] = term_ff[j-1];
         assign acc_in[j]  = acc_ff[j-1];
      end

      // reciprocal estimate is low by at most one
      always_comb begin
         rem = pb_ff[j] - 32'(qe_ff[j] * 32'(j));
         q   = 33'(qe_ff[j]) + 33'(rem >= 32'(j));
      end

      always_ff @(posedge clock) begin
         if (en) begin
            p_ff[j]    <= 32'((65'(term_in[j]) * 65'(u_ff[3*j])) >> 32);
            acca_ff[j] <= acc_in[j];
            qe_ff[j]   <= 32'((69'(p_ff[j]) * 69'(RECIP)) >> 36);
            pb_ff[j]   <= p_ff[j];
            accb_ff[j] <= acca_ff[j];
            term_ff[j] <= q;
            if (j % 2 == 1)
               acc_ff[j] <= accb_ff[j] - $signed({2'b00, q});
            else
               acc_ff[j] <= accb_ff[j] + $signed({2'b00, q});
         end
      end
   end

   assign e = e_ff;

endmodule
